>>> rtl/core/nj_pkg.sv
package nj_pkg;

    localparam int MAX_LEAVES_DEF = 32;
    localparam int DIST_WIDTH_DEF = 32;
    localparam int NODE_W         = 6;
    localparam int LEAF_W         = 5;
    localparam int IN_DIST_W      = 32;
    localparam int OUT_DIST_W     = 32;
    localparam int CFG_W          = 6;

    // saturate a signed 64-bit value to a width given by bits
    function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                                input int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            if (v > hi)
                sat64 = hi;
            else if (v < lo)
                sat64 = lo;
            else
                sat64 = v;
        end
    endfunction

endpackage

>>> rtl/core/nj_if.sv
interface nj_in_if;
    logic                   valid;
    logic                   ready;
    logic [4:0]             row_index;
    logic [4:0]             column_index;
    logic signed [31:0]     distance;
    logic                   last_entry;
    modport source (output valid, row_index, column_index, distance, last_entry, input ready);
    modport sink   (input valid, row_index, column_index, distance, last_entry, output ready);
endinterface

interface nj_out_if;
    logic                   valid;
    logic                   ready;
    logic [5:0]             parent_node;
    logic [5:0]             first_child;
    logic [5:0]             second_child;
    logic signed [31:0]     first_branch;
    logic signed [31:0]     second_branch;
    logic                   last_merge;
    modport source (output valid, parent_node, first_child, second_child, first_branch,
                    second_branch, last_merge, input ready);
    modport sink   (input valid, parent_node, first_child, second_child, first_branch,
                    second_branch, last_merge, output ready);
endinterface

>>> rtl/core/nj_dist_ram.sv
module nj_dist_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/neighbor_joining_tree_builder.sv
// channel   dir  payload                                             handshake
// in_ch     in   row_index, column_index, distance, last_entry       valid/ready
// out_ch    out  parent_node, first/second_child, branches, last     valid/ready
// cfg       in   leaf_count (6 bits)                                 cfg_we
//
// a matrix beat is written twice: the accept writes one triangle, the next cycle the mirror
// the build after the last beat is sequenced over the distance memory (registered read):
// a round reads all m*m entries for the row sums, runs the m*(m-1)/2 pair checks (read,
// serial divide, compare) and then updates the merged row and its mirror
// each merge beat waits in the output register; the sequencer stalls until it is free
// reset (async, active low) clears control state; memory contents stay undefined
module neighbor_joining_tree_builder #(
    parameter int MAX_LEAVES = nj_pkg::MAX_LEAVES_DEF,
    parameter int DIST_WIDTH = nj_pkg::DIST_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [nj_pkg::CFG_W-1:0]  cfg_wdata,
    nj_in_if.sink                     in_ch,
    nj_out_if.source                  out_ch
);

    localparam int RW    = $clog2(MAX_LEAVES);
    localparam int AW    = 2 * RW;
    localparam int DEPTH = 1 << AW;
    localparam int CAP   = (MAX_LEAVES < 32) ? MAX_LEAVES : 32;
    localparam int CW    = 7;   // counts up to 64
    localparam int SW    = DIST_WIDTH + 8;

    typedef enum logic [4:0] {
        S_IDLE, S_WR2, S_INIT, S_SUM_RD, S_SUM_ACC, S_Q_RD, S_Q_DIV, S_Q_CMP,
        S_BR_RD, S_BR_DIV, S_BR_OUT, S_UPD_A, S_UPD_B, S_UPD_W1, S_UPD_W2,
        S_SHIFT, S_FIN_RD, S_FIN_OUT, S_WAIT
    } state_t;

    state_t state_reg;
    state_t ret_reg;

    logic [nj_pkg::CFG_W-1:0] leaf_count_reg;

    // row tables (small, fixed-read via counters)
    logic [RW-1:0]            act_reg  [MAX_LEAVES];
    logic [nj_pkg::NODE_W-1:0] nmap_reg [MAX_LEAVES];
    logic signed [SW-1:0]     rsum_reg [MAX_LEAVES];

    logic [CW-1:0] m_reg, i_reg, j_reg, bi_reg, bj_reg;
    logic [nj_pkg::NODE_W-1:0] next_node_reg;
    logic signed [SW-1:0] acc_reg;
    logic signed [SW+1:0] best_reg, q_reg;
    logic have_reg;
    logic signed [DIST_WIDTH-1:0] d_reg, dab_reg, dac_reg;
    logic [RW-1:0] wr_r_reg, wr_c_reg;
    logic signed [DIST_WIDTH-1:0] wr_d_reg;

    // divider: signed numerator by small unsigned divisor, restoring, one bit a cycle
    logic signed [SW+1:0] div_num_reg;
    logic [SW+1:0] div_quo_reg, div_rem_reg;
    logic [CW-1:0] div_den_reg;
    logic [6:0] div_cnt_reg;
    logic div_neg_reg;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [DIST_WIDTH-1:0] mem_wd, mem_rd;

    nj_dist_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DIST_WIDTH)) u_ram (
        .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
        .raddr(mem_ra), .rdata(mem_rd)
    );

    logic [RW-1:0] ar_i, ar_j, ar_bi, ar_bj;
    assign ar_i  = act_reg[i_reg[RW-1:0]];
    assign ar_j  = act_reg[j_reg[RW-1:0]];
    assign ar_bi = act_reg[bi_reg[RW-1:0]];
    assign ar_bj = act_reg[bj_reg[RW-1:0]];

    logic in_ok;
    assign in_ok = (CW'(in_ch.row_index) < CW'(MAX_LEAVES))
                && (CW'(in_ch.column_index) < CW'(MAX_LEAVES));
    assign in_ch.ready = (state_reg == S_IDLE);

    logic signed [63:0] in_sat;
    assign in_sat = nj_pkg::sat64(64'(in_ch.distance), DIST_WIDTH);

    // write port and read address
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = {wr_r_reg, wr_c_reg};
        mem_wd = wr_d_reg;
        mem_ra = {ar_i, ar_j};
        case (state_reg)
            S_IDLE:
            begin
                mem_we = in_ch.valid && in_ok;
                mem_wa = {RW'(in_ch.row_index), RW'(in_ch.column_index)};
                mem_wd = in_sat[DIST_WIDTH-1:0];
            end
            S_WR2:    mem_we = 1'b1;
            S_BR_RD:  mem_ra = {ar_bi, ar_bj};
            S_FIN_RD, S_FIN_OUT: mem_ra = {act_reg[1], act_reg[0]};
            S_UPD_A:  mem_ra = {ar_bi, ar_i};
            S_UPD_B:  mem_ra = {ar_bj, ar_i};
            S_UPD_W2: mem_we = 1'b1;
            S_WAIT:
            begin
                mem_we = 1'b1;
                mem_wa = {wr_c_reg, wr_r_reg};
            end
            default: ;
        endcase
    end

    logic signed [SW+1:0] div_q_signed;
    assign div_q_signed = div_neg_reg ? -$signed(div_quo_reg) : $signed(div_quo_reg);

    logic signed [SW+1:0] sum_ij, diff_ij;
    assign sum_ij  = (SW+2)'(rsum_reg[ar_i]) + (SW+2)'(rsum_reg[ar_j]);
    assign diff_ij = (SW+2)'(rsum_reg[ar_bi]) - (SW+2)'(rsum_reg[ar_bj]);

    logic signed [SW+1:0] blen_full, upd_full;
    assign blen_full = ((SW+2)'(dab_reg) + div_q_signed) / 2;
    assign upd_full  = ((SW+2)'(dac_reg) + (SW+2)'($signed(mem_rd)) - (SW+2)'(d_reg)) / 2;

    logic [SW+1:0] rem_sh;
    assign rem_sh = {div_rem_reg[SW:0], div_num_reg[SW+1]};

    logic signed [63:0] sat_o1, sat_o2, sat_up;
    logic signed [SW+1:0] b2_full;
    assign b2_full = (blen_full > 0) ? ((SW+2)'(dab_reg) - blen_full) : (SW+2)'(dab_reg);
    assign sat_o1 = nj_pkg::sat64(64'((blen_full > 0) ? blen_full : '0), 32);
    assign sat_o2 = nj_pkg::sat64(64'(b2_full), 32);
    assign sat_up = nj_pkg::sat64(64'(upd_full), DIST_WIDTH);

    logic [CW-1:0] n_clamp;
    always_comb
    begin
        n_clamp = CW'(leaf_count_reg);
        if (n_clamp < CW'(2))
            n_clamp = CW'(2);
        if (n_clamp > CW'(CAP))
            n_clamp = CW'(CAP);
    end

    logic signed [63:0] half_full, half_sat;
    assign half_full = 64'($signed(mem_rd)) / 2;
    assign half_sat  = nj_pkg::sat64(half_full, 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            leaf_count_reg <= nj_pkg::CFG_W'(2);
            out_ch.valid   <= 1'b0;
            out_ch.parent_node   <= '0;
            out_ch.first_child   <= '0;
            out_ch.second_child  <= '0;
            out_ch.first_branch  <= '0;
            out_ch.second_branch <= '0;
            out_ch.last_merge    <= 1'b0;
            next_node_reg  <= nj_pkg::NODE_W'(2);
            m_reg <= CW'(2); i_reg <= '0; j_reg <= '0; bi_reg <= '0; bj_reg <= '0;
            have_reg <= 1'b0;
            div_cnt_reg <= '0;
            div_num_reg <= '0; div_quo_reg <= '0; div_rem_reg <= '0;
            div_den_reg <= '0; div_neg_reg <= 1'b0;
            acc_reg <= '0; best_reg <= '0; q_reg <= '0;
            d_reg <= '0; dab_reg <= '0; dac_reg <= '0;
            wr_r_reg <= '0; wr_c_reg <= '0; wr_d_reg <= '0;
            for (int k = 0; k < MAX_LEAVES; k++)
            begin
                act_reg[k]  <= RW'(k);
                nmap_reg[k] <= nj_pkg::NODE_W'(k);
                rsum_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                leaf_count_reg <= cfg_wdata;
            if (out_ch.valid && out_ch.ready)
                out_ch.valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        wr_r_reg <= RW'(in_ch.column_index);
                        wr_c_reg <= RW'(in_ch.row_index);
                        wr_d_reg <= in_sat[DIST_WIDTH-1:0];
                        ret_reg  <= in_ch.last_entry ? S_INIT : S_IDLE;
                        state_reg <= in_ok ? S_WR2 : (in_ch.last_entry ? S_INIT : S_IDLE);
                    end
                end
                S_WR2: state_reg <= ret_reg;
                S_INIT:
                begin
                    for (int k = 0; k < MAX_LEAVES; k++)
                    begin
                        act_reg[k]  <= RW'(k);
                        nmap_reg[k] <= nj_pkg::NODE_W'(k);
                    end
                    m_reg <= n_clamp;
                    next_node_reg <= nj_pkg::NODE_W'(n_clamp);
                    i_reg <= '0; j_reg <= '0; acc_reg <= '0;
                    state_reg <= (n_clamp > CW'(2)) ? S_SUM_RD : S_FIN_RD;
                end
                S_SUM_RD: state_reg <= S_SUM_ACC;
                S_SUM_ACC:
                begin
                    if (j_reg + CW'(1) == m_reg)
                    begin
                        rsum_reg[ar_i] <= acc_reg + SW'($signed(mem_rd));
                        acc_reg <= '0;
                        j_reg <= '0;
                        if (i_reg + CW'(1) == m_reg)
                        begin
                            i_reg <= CW'(1);
                            have_reg <= 1'b0;
                            state_reg <= S_Q_RD;
                        end
                        else
                        begin
                            i_reg <= i_reg + CW'(1);
                            state_reg <= S_SUM_RD;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_reg + SW'($signed(mem_rd));
                        j_reg <= j_reg + CW'(1);
                        state_reg <= S_SUM_RD;
                    end
                end
                S_Q_RD:
                begin
                    div_neg_reg <= sum_ij[SW+1];
                    div_num_reg <= sum_ij[SW+1] ? -sum_ij : sum_ij;
                    div_rem_reg <= '0;
                    div_den_reg <= m_reg - CW'(2);
                    div_cnt_reg <= 7'(SW + 2);
                    ret_reg <= S_Q_CMP;
                    state_reg <= S_Q_DIV;
                end
                S_Q_DIV, S_BR_DIV:
                begin
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= ret_reg;
                        if (state_reg == S_Q_DIV)
                            q_reg <= (SW+2)'($signed(d_reg)) - div_q_signed;
                    end
                    else
                    begin
                        div_num_reg <= div_num_reg <<< 1;
                        if (rem_sh >= (SW+2)'(div_den_reg))
                        begin
                            div_rem_reg <= rem_sh - (SW+2)'(div_den_reg);
                            div_quo_reg <= {div_quo_reg[SW:0], 1'b1};
                        end
                        else
                        begin
                            div_rem_reg <= rem_sh;
                            div_quo_reg <= {div_quo_reg[SW:0], 1'b0};
                        end
                        div_cnt_reg <= div_cnt_reg - 7'd1;
                    end
                    if (state_reg == S_Q_DIV && div_cnt_reg == 7'(SW + 2))
                        d_reg <= $signed(mem_rd);
                end
                S_Q_CMP:
                begin
                    if (!have_reg || q_reg < best_reg)
                    begin
                        best_reg <= q_reg;
                        bi_reg <= i_reg;
                        bj_reg <= j_reg;
                        have_reg <= 1'b1;
                    end
                    if (j_reg + CW'(1) == i_reg)
                    begin
                        j_reg <= '0;
                        if (i_reg + CW'(1) == m_reg)
                            state_reg <= S_BR_RD;
                        else
                        begin
                            i_reg <= i_reg + CW'(1);
                            state_reg <= S_Q_RD;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + CW'(1);
                        state_reg <= S_Q_RD;
                    end
                end
                S_BR_RD:
                begin
                    div_neg_reg <= diff_ij[SW+1];
                    div_num_reg <= diff_ij[SW+1] ? -diff_ij : diff_ij;
                    div_rem_reg <= '0;
                    div_den_reg <= m_reg - CW'(2);
                    div_cnt_reg <= 7'(SW + 2);
                    ret_reg <= S_BR_OUT;
                    state_reg <= S_BR_DIV;
                end
                S_BR_OUT:
                begin
                    if (!out_ch.valid)
                    begin
                        out_ch.valid <= 1'b1;
                        out_ch.parent_node   <= next_node_reg;
                        out_ch.first_child   <= nmap_reg[ar_bi];
                        out_ch.second_child  <= nmap_reg[ar_bj];
                        out_ch.first_branch  <= sat_o1[31:0];
                        out_ch.second_branch <= sat_o2[31:0];
                        out_ch.last_merge    <= 1'b0;
                        nmap_reg[ar_bj] <= next_node_reg;
                        next_node_reg <= next_node_reg + 1'b1;
                        d_reg <= dab_reg;
                        i_reg <= '0;
                        state_reg <= S_UPD_A;
                    end
                end
                S_UPD_A:
                begin
                    if (i_reg == m_reg)
                    begin
                        i_reg <= bi_reg;
                        state_reg <= S_SHIFT;
                    end
                    else if (i_reg == bi_reg || i_reg == bj_reg)
                        i_reg <= i_reg + CW'(1);
                    else
                        state_reg <= S_UPD_B;
                end
                S_UPD_B:
                begin
                    dac_reg <= $signed(mem_rd);
                    state_reg <= S_UPD_W1;
                    wr_r_reg <= ar_bj;
                    wr_c_reg <= ar_i;
                end
                S_UPD_W1:
                begin
                    // mem_rd holds d(b,c) here; the two mirror writes follow
                    wr_d_reg <= sat_up[DIST_WIDTH-1:0];
                    state_reg <= S_UPD_W2;
                end
                S_UPD_W2:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    i_reg <= i_reg + CW'(1);
                    state_reg <= S_UPD_A;
                end
                S_SHIFT:
                begin
                    if (i_reg + CW'(1) >= m_reg)
                    begin
                        m_reg <= m_reg - CW'(1);
                        i_reg <= '0; j_reg <= '0; acc_reg <= '0;
                        state_reg <= (m_reg - CW'(1) > CW'(2)) ? S_SUM_RD : S_FIN_RD;
                    end
                    else
                    begin
                        act_reg[i_reg[RW-1:0]] <= act_reg[RW'(i_reg + CW'(1))];
                        i_reg <= i_reg + CW'(1);
                    end
                end
                S_FIN_RD: state_reg <= S_FIN_OUT;
                S_FIN_OUT:
                begin
                    if (!out_ch.valid)
                    begin
                        out_ch.valid <= 1'b1;
                        out_ch.parent_node   <= next_node_reg;
                        out_ch.first_child   <= nmap_reg[act_reg[1]];
                        out_ch.second_child  <= nmap_reg[act_reg[0]];
                        out_ch.first_branch  <= half_sat[31:0];
                        out_ch.second_branch <= half_sat[31:0];
                        out_ch.last_merge    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_BR_DIV && div_cnt_reg == 7'(SW + 2))
                dab_reg <= $signed(mem_rd);
        end
    end

endmodule
